/* hw/rtl/sida_pkg.sv */
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int NUM_W      = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 6;
	localparam int CHAR_W     = 8;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_stat_t;

endpackage

/* hw/rtl/sida_bcd.sv */
// ----------------------------------------------------------------------------
// sida_bcd
// Bit-serial binary to BCD converter (shift and add-three), one bit a cycle.
// ----------------------------------------------------------------------------
module sida_bcd
	import sida_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] mag,
	output digits_t          digits,
	output conv_stat_t       stat
);

	logic [NUM_W-1:0] mag_q;
	digits_t          bcd_q;
	digits_t          adj;
	digits_t          bcd_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= DIGIT_FIVE) ? bcd_q[i] + DIGIT_ADJ : bcd_q[i];
		end
		bcd_nxt[0] = {adj[0][DIGIT_W-2:0], mag_q[NUM_W-1]};
		for (int i = 1; i < NUM_DIGITS; i++) begin
			bcd_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			bcd_q <= bcd_nxt;
		end
	end

	assign digits    = bcd_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer to its decimal ASCII text, sign first,
// most significant digit first, no leading zeros, last character marked.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------
//   input   | in_valid  | in_stall  | number
//   output  | out_valid | out_stall | character, final_char
//
// An item has n = 1..11 characters. It is loaded and run through the
// one-bit-a-cycle BCD converter, its leading digit is picked, and then
// one character a cycle goes out while the output is not stalled. The
// next item is taken in the cycle after the last character enters the
// output register. Reset clears the control state only. A stalled output
// holds its character and pauses the character sequence.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
	import sida_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [NUM_W-1:0] number,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       character,
	output logic                    final_char
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic              neg_q;
	logic              sign_pend_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              final_q;

	logic              in_xfer;
	logic              load;
	logic [NUM_W-1:0]  mag;
	logic [IDX_W-1:0]  lead;
	digits_t           digits;
	conv_stat_t        conv_stat;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign mag      = number[NUM_W-1] ? NUM_W'(0) - NUM_W'(number) : NUM_W'(number);

	// highest nonzero digit, zero when the value is zero
	always_comb begin
		lead = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digits[i] != '0) begin
				lead = IDX_W'(i);
			end
		end
	end

	sida_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.mag    (mag),
		.digits (digits),
		.stat   (conv_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						neg_q   <= number[NUM_W-1];
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_stat.done && !conv_stat.busy) begin
						idx_q       <= lead;
						sign_pend_q <= neg_q;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sign_pend_q) begin
				char_q  <= CHAR_MINUS;
				final_q <= 1'b0;
			end else begin
				char_q  <= CHAR_ZERO + CHAR_W'(digits[idx_q]);
				final_q <= (idx_q == '0);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign final_char = final_q;

endmodule

/* hw/rtl/sida_checker.sv */
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
module sida_checker
	import sida_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [NUM_W-1:0]  number,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] character,
	input logic              final_char
);

	// stalled output transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(final_char))
		else $error("stalled output changed");

	// one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> character == CHAR_MINUS ||
			(character >= CHAR_ZERO && character <= CHAR_ZERO + 8'd9))
		else $error("character not a digit or minus");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == CHAR_MINUS |-> !final_char)
		else $error("minus sign marked last");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.number     (number),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.character  (character),
	.final_char (final_char)
);

/* dv/signed_int_to_decimal_ascii_unit_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Drives signed 32-bit numbers into the decimal text unit and checks every
// output character and its last-character mark. The expected text comes from
// a typed-in string for the obvious directed rows and from a software itoa
// for the rest. A table of directed rows runs first, then random numbers
// spread over every digit count. Random idling on both channels runs in three
// phases: mostly receiver idling, then mostly sender idling, then none.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb
	import sida_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEC_BASE     = 10;
	localparam int RANDOM_ITEMS = 90;
	localparam int DIRECTED_N   = 20;
	localparam int TOTAL_ITEMS  = DIRECTED_N + RANDOM_ITEMS;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	typedef struct {
		logic [NUM_W-1:0] value;
		string            text;
	} number_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [NUM_W-1:0] number = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [CHAR_W-1:0]       character;
	logic                    final_char;

	text_char_t pending_chars[$];
	text_char_t expected_char;
	int         error_count = 0;
	int         sender_idle_pct = 0;
	int         receiver_idle_pct = 0;

	// empty text means the row is checked against the software conversion
	number_row_t directed_rows[DIRECTED_N] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'hFFFF_FFFF,  "-1"},
		'{32'd2147483647, "2147483647"},
		'{32'h8000_0000,  "-2147483648"},
		'{32'h8000_0001,  ""},
		'{32'd9,          ""},
		'{32'd10,         ""},
		'{32'hFFFF_FFF7,  ""},
		'{32'hFFFF_FFF6,  ""},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'd999999999,  ""},
		'{32'd1000000000, ""},
		'{32'hC465_3600,  ""},
		'{32'd1234567890, ""},
		'{32'hC521_974F,  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'h7FFF_FFFE,  ""}
	};

	signed_int_to_decimal_ascii_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.number     (number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.final_char (final_char)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void predict_decimal_text(input logic [NUM_W-1:0] value);
		logic [NUM_W-1:0]   mag;
		logic [DIGIT_W-1:0] digs[$];
		if (value[NUM_W-1]) begin
			pending_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0});
			mag = -value;
		end else begin
			mag = value;
		end
		do begin
			digs.push_front(DIGIT_W'(mag % DEC_BASE));
			mag = mag / DEC_BASE;
		end while (mag != 0);
		foreach (digs[i])
			pending_chars.push_back(text_char_t'{CHAR_ZERO + CHAR_W'(digs[i]),
				i == digs.size() - 1});
	endfunction

	function automatic void push_typed_text(input string text);
		for (int i = 0; i < text.len(); i++)
			pending_chars.push_back(text_char_t'{CHAR_W'(text[i]), i == text.len() - 1});
	endfunction

	function automatic logic [NUM_W-1:0] random_number();
		logic [NUM_W-1:0] mag;
		int               ndig;
		longint           span;
		if ($urandom_range(3) == 0)
			return $urandom;
		ndig = $urandom_range(1, NUM_DIGITS - 1);
		span = 1;
		repeat (ndig) span = span * DEC_BASE;
		mag = NUM_W'(longint'($urandom) % span);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	task automatic set_idle_phase(input int idx);
		case (idx * 3 / TOTAL_ITEMS)
			0: begin
				sender_idle_pct   = 32;
				receiver_idle_pct = 85;
			end
			1: begin
				sender_idle_pct   = 85;
				receiver_idle_pct = 32;
			end
			default: begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
		endcase
	endtask

	task automatic send_number(input logic [NUM_W-1:0] value, input string text);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		number   <= value;
		do @(posedge clk); while (in_stall);
		if (text.len() == 0)
			predict_decimal_text(value);
		else
			push_typed_text(text);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// output transfer check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				error_count++;
				$error("unexpected character: actual %0d final_char %0b", character,
					final_char);
			end else begin
				expected_char = pending_chars.pop_front();
				if (character !== expected_char.code) begin
					error_count++;
					$error("character: expected %0d actual %0d", expected_char.code,
						character);
				end
				if (final_char !== expected_char.last) begin
					error_count++;
					$error("final_char: expected %0b actual %0b", expected_char.last,
						final_char);
				end
			end
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIRECTED_N; i++) begin
			set_idle_phase(i);
			send_number(directed_rows[i].value, directed_rows[i].text);
		end
		for (int i = DIRECTED_N; i < TOTAL_ITEMS; i++) begin
			set_idle_phase(i);
			send_number(random_number(), "");
		end
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			error_count++;
			$error("%0d expected characters never arrived", pending_chars.size());
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* signed_int_to_decimal_ascii_unit.f */
hw/rtl/sida_pkg.sv
hw/rtl/sida_bcd.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
hw/rtl/sida_checker.sv
dv/signed_int_to_decimal_ascii_unit_tb.sv
